### rtl/assert_macros.svh
// Assertion helpers shared by the checking code of the color decode unit.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, ignored while reset is asserted.
`define PMCD_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("pmcd: implication check failed");

// Next-cycle implication, ignored while reset is asserted.
`define PMCD_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("pmcd: next-cycle check failed");

`endif

### rtl/pmcd_pkg.sv
// ----------------------------------------------------------------------------
// pmcd_pkg
// Types, codes and constants of the pixel map color decode unit.
// ----------------------------------------------------------------------------
package pmcd_pkg;

    localparam int PMCD_TABLE_DEPTH = 256;
    localparam int CFG_IDX_W        = 3;
    localparam int CFG_DATA_W       = 16;

    // Pixel kinds and supported sizes.
    localparam logic [15:0] KIND_INDEXED = 16'h0000;
    localparam logic [15:0] KIND_DIRECT  = 16'h0010;
    localparam logic [5:0]  BITS_16      = 6'd16;
    localparam logic [5:0]  BITS_32      = 6'd32;
    localparam logic [4:0]  COMP_BITS_5  = 5'd5;
    localparam logic [4:0]  COMP_BITS_8  = 5'd8;
    localparam logic [3:0]  COMP_COUNT_3 = 4'd3;
    localparam logic [7:0]  ALPHA_OPAQUE = 8'hFF;

    // Configuration register indexes.
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_PIXEL_KIND      = 3'd0,
        CFG_PIXEL_BITS      = 3'd1,
        CFG_COMPONENT_BITS  = 3'd2,
        CFG_COMPONENT_COUNT = 3'd3,
        CFG_SLOT_MODE       = 3'd4,
        CFG_TABLE_COUNT     = 3'd5,
        CFG_MASK_PRESENT    = 3'd6
    } cfg_idx_t;

    // Result status codes.
    localparam logic [1:0] ST_OK         = 2'd0;
    localparam logic [1:0] ST_NOT_FOUND  = 2'd1;
    localparam logic [1:0] ST_BAD_FORMAT = 2'd2;
    localparam logic [1:0] ST_NO_TABLE   = 2'd3;

    // Request kinds.
    localparam logic REQ_PIXEL = 1'b0;
    localparam logic REQ_WRITE = 1'b1;

    typedef struct packed {
        logic        req_type;
        logic [31:0] pixel_value;
        logic        mask_bit;
        logic [7:0]  entry_slot;
        logic [15:0] entry_number;
        logic [15:0] entry_red;
        logic [15:0] entry_green;
        logic [15:0] entry_blue;
    } pmcd_req_t;

    typedef struct packed {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
        logic [7:0] alpha;
        logic [1:0] status;
    } pmcd_res_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_DECODE,
        S_SEARCH,
        S_COLOR,
        S_FINISH
    } pmcd_state_t;

    typedef enum logic [3:0] {
        CMD_NONE,
        CMD_LOAD,
        CMD_RES_DECODE,
        CMD_SEARCH_START,
        CMD_SEARCH_STEP,
        CMD_READ_COLOR,
        CMD_RES_COLOR,
        CMD_RES_MISS,
        CMD_OUT
    } pmcd_op_t;

    typedef struct packed {
        pmcd_op_t op;
    } pmcd_cmd_t;

    typedef struct packed {
        logic no_lookup;   // table write, format error or direct pixel
        logic slot_mode;
        logic slot_hit;
        logic num_match;
        logic search_end;
        logic out_free;
    } pmcd_sts_t;

endpackage

### rtl/pmcd_ifs.sv
// ----------------------------------------------------------------------------
// pmcd_ifs
// Valid/ready channels for pixel requests and decoded colors.
// ----------------------------------------------------------------------------
interface pmcd_req_if;
    logic        valid;
    logic        ready;
    logic        req_type;
    logic [31:0] pixel_value;
    logic        mask_bit;
    logic [7:0]  entry_slot;
    logic [15:0] entry_number;
    logic [15:0] entry_red;
    logic [15:0] entry_green;
    logic [15:0] entry_blue;

    modport source (output valid, req_type, pixel_value, mask_bit, entry_slot,
                    entry_number, entry_red, entry_green, entry_blue, input ready);
    modport sink   (input valid, req_type, pixel_value, mask_bit, entry_slot,
                    entry_number, entry_red, entry_green, entry_blue, output ready);
endinterface

interface pmcd_res_if;
    logic       valid;
    logic       ready;
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic [7:0] alpha;
    logic [1:0] status;

    modport source (output valid, red, green, blue, alpha, status, input ready);
    modport sink   (input valid, red, green, blue, alpha, status, output ready);
endinterface

### rtl/pmcd_ctrl.sv
// ----------------------------------------------------------------------------
// pmcd_ctrl
// Sequencer: decode, optional table search, color read and result hand-off.
// ----------------------------------------------------------------------------
module pmcd_ctrl
    import pmcd_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      in_valid,
    output logic      in_ready,
    input  pmcd_sts_t sts,
    output pmcd_cmd_t cmd
);

    pmcd_state_t state_reg;
    pmcd_state_t state_next;

    // State register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = S_DECODE;
                end
            end
            S_DECODE:
            begin
                priority if (sts.no_lookup)
                begin
                    state_next = S_FINISH;
                end
                else if (sts.slot_mode)
                begin
                    state_next = sts.slot_hit ? S_COLOR : S_FINISH;
                end
                else
                begin
                    state_next = S_SEARCH;
                end
            end
            S_SEARCH:
            begin
                priority if (sts.num_match)
                begin
                    state_next = S_COLOR;
                end
                else if (sts.search_end)
                begin
                    state_next = S_FINISH;
                end
            end
            S_COLOR:
            begin
                state_next = S_FINISH;
            end
            S_FINISH:
            begin
                if (sts.out_free)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Outputs.
    always_comb
    begin
        cmd.op   = CMD_NONE;
        in_ready = 1'b0;
        unique case (state_reg)
            S_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.op = CMD_LOAD;
                end
            end
            S_DECODE:
            begin
                priority if (sts.no_lookup)
                begin
                    cmd.op = CMD_RES_DECODE;
                end
                else if (sts.slot_mode)
                begin
                    cmd.op = sts.slot_hit ? CMD_READ_COLOR : CMD_RES_MISS;
                end
                else
                begin
                    cmd.op = CMD_SEARCH_START;
                end
            end
            S_SEARCH:
            begin
                priority if (sts.num_match)
                begin
                    cmd.op = CMD_READ_COLOR;
                end
                else if (sts.search_end)
                begin
                    cmd.op = CMD_RES_MISS;
                end
                else
                begin
                    cmd.op = CMD_SEARCH_STEP;
                end
            end
            S_COLOR:
            begin
                cmd.op = CMD_RES_COLOR;
            end
            S_FINISH:
            begin
                if (sts.out_free)
                begin
                    cmd.op = CMD_OUT;
                end
            end
            default:
            begin
                cmd.op = CMD_NONE;
            end
        endcase
    end

endmodule

### rtl/pmcd_datapath.sv
// ----------------------------------------------------------------------------
// pmcd_datapath
// Configuration, color table memories, format checks and the result register.
// ----------------------------------------------------------------------------
module pmcd_datapath
    import pmcd_pkg::*;
#(
    parameter int TABLE_DEPTH = PMCD_TABLE_DEPTH
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    input  pmcd_req_t             req,
    input  pmcd_cmd_t             cmd,
    output pmcd_sts_t             sts,
    output logic                  out_valid,
    input  logic                  out_ready,
    output pmcd_res_t             res
);

    localparam int AW = $clog2(TABLE_DEPTH);

    // Configuration registers.
    logic [15:0] pixel_kind_reg;
    logic [5:0]  pixel_bits_reg;
    logic [4:0]  component_bits_reg;
    logic [3:0]  component_count_reg;
    logic        slot_mode_reg;
    logic [8:0]  table_count_reg;
    logic        mask_present_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pixel_kind_reg      <= KIND_INDEXED;
            pixel_bits_reg      <= 6'd8;
            component_bits_reg  <= 5'd0;
            component_count_reg <= COMP_COUNT_3;
            slot_mode_reg       <= 1'b0;
            table_count_reg     <= 9'd0;
            mask_present_reg    <= 1'b0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_PIXEL_KIND:      pixel_kind_reg      <= cfg_data[15:0];
                CFG_PIXEL_BITS:      pixel_bits_reg      <= cfg_data[5:0];
                CFG_COMPONENT_BITS:  component_bits_reg  <= cfg_data[4:0];
                CFG_COMPONENT_COUNT: component_count_reg <= cfg_data[3:0];
                CFG_SLOT_MODE:       slot_mode_reg       <= cfg_data[0];
                CFG_TABLE_COUNT:     table_count_reg     <= cfg_data[8:0];
                CFG_MASK_PRESENT:    mask_present_reg    <= cfg_data[0];
                default:             ;
            endcase
        end
    end

    // Latched transaction.
    pmcd_req_t item_reg;

    always_ff @(posedge clk)
    begin
        if (cmd.op == CMD_LOAD)
        begin
            item_reg <= req;
        end
    end

    // Format checks in priority order.
    logic        kind_ok;
    logic        indexed;
    logic        bits_ok;
    logic        direct_bad;
    logic [1:0]  fmt_status;
    logic [31:0] ones;
    logic [31:0] code;
    logic [15:0] id;
    logic [31:0] count32;
    logic [31:0] tc32;

    always_comb
    begin
        kind_ok = (pixel_kind_reg == KIND_INDEXED) || (pixel_kind_reg == KIND_DIRECT);
        indexed = (pixel_kind_reg == KIND_INDEXED);
        bits_ok = (pixel_bits_reg == 6'd1) || (pixel_bits_reg == 6'd2) ||
                  (pixel_bits_reg == 6'd4) || (pixel_bits_reg == 6'd8) ||
                  (pixel_bits_reg == BITS_16) || (pixel_bits_reg == BITS_32);
        direct_bad = (component_count_reg != COMP_COUNT_3) ||
                     ((pixel_bits_reg == BITS_16) && (component_bits_reg != COMP_BITS_5)) ||
                     ((pixel_bits_reg == BITS_32) && (component_bits_reg != COMP_BITS_8));
        priority if (!kind_ok)
        begin
            fmt_status = ST_BAD_FORMAT;
        end
        else if (indexed && (table_count_reg == 9'd0))
        begin
            fmt_status = ST_NO_TABLE;
        end
        else if (!indexed && direct_bad)
        begin
            fmt_status = ST_BAD_FORMAT;
        end
        else if (!bits_ok)
        begin
            fmt_status = ST_BAD_FORMAT;
        end
        else if (!indexed && (pixel_bits_reg < BITS_16))
        begin
            fmt_status = ST_BAD_FORMAT;
        end
        else
        begin
            fmt_status = ST_OK;
        end
        ones    = (pixel_bits_reg >= BITS_32) ? 32'hFFFF_FFFF
                                              : ((32'd1 << pixel_bits_reg) - 32'd1);
        code    = item_reg.pixel_value & ones;
        id      = code[15:0];
        tc32    = 32'(table_count_reg);
        count32 = (tc32 > 32'(TABLE_DEPTH)) ? 32'(TABLE_DEPTH) : tc32;
    end

    // Color table memories; only the top byte of each channel is kept.
    logic [15:0]   num_mem [TABLE_DEPTH];
    logic [23:0]   col_mem [TABLE_DEPTH];
    logic [15:0]   num_rd_reg;
    logic [23:0]   col_rd_reg;
    logic [AW-1:0] idx_reg;
    logic [AW-1:0] num_addr;
    logic [AW-1:0] col_addr;
    logic [31:0]   slot32;
    logic [31:0]   id32;
    logic          mem_we;

    always_comb
    begin
        slot32   = 32'(item_reg.entry_slot);
        id32     = 32'(id);
        mem_we   = (cmd.op == CMD_RES_DECODE) && (item_reg.req_type == REQ_WRITE) &&
                   (slot32 < 32'(TABLE_DEPTH));
        num_addr = (cmd.op == CMD_SEARCH_STEP) ? idx_reg + AW'(1) : '0;
        col_addr = slot_mode_reg ? id32[AW-1:0] : idx_reg;
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            num_mem[slot32[AW-1:0]] <= item_reg.entry_number;
            col_mem[slot32[AW-1:0]] <= {item_reg.entry_red[15:8], item_reg.entry_green[15:8],
                                        item_reg.entry_blue[15:8]};
        end
        num_rd_reg <= num_mem[num_addr];
        col_rd_reg <= col_mem[col_addr];
    end

    // Search index: points at the entry whose number is in num_rd_reg.
    always_ff @(posedge clk)
    begin
        if ((cmd.op == CMD_SEARCH_START) || (cmd.op == CMD_SEARCH_STEP))
        begin
            idx_reg <= num_addr;
        end
    end

    // Status toward the controller.
    assign sts.no_lookup  = (item_reg.req_type == REQ_WRITE) || (fmt_status != ST_OK) ||
                            !indexed;
    assign sts.slot_mode  = slot_mode_reg;
    assign sts.slot_hit   = id32 < count32;
    assign sts.num_match  = num_rd_reg == id;
    assign sts.search_end = (32'(idx_reg) + 32'd1) >= count32;
    assign sts.out_free   = !out_valid || out_ready;

    // Working result, built in the decode, miss or color step.
    pmcd_res_t work_reg;
    pmcd_res_t work_next;

    always_comb
    begin
        work_next = work_reg;
        unique case (cmd.op)
            CMD_RES_DECODE:
            begin
                work_next = '0;
                priority if (item_reg.req_type == REQ_WRITE)
                begin
                    work_next = '0;
                end
                else if (fmt_status != ST_OK)
                begin
                    work_next.status = fmt_status;
                end
                else if (pixel_bits_reg == BITS_16)
                begin
                    work_next.red   = {code[14:10], code[14:12]};
                    work_next.green = {code[9:5], code[9:7]};
                    work_next.blue  = {code[4:0], code[4:2]};
                    work_next.alpha = ALPHA_OPAQUE;
                end
                else
                begin
                    work_next.red   = code[23:16];
                    work_next.green = code[15:8];
                    work_next.blue  = code[7:0];
                    work_next.alpha = ALPHA_OPAQUE;
                end
            end
            CMD_RES_MISS:
            begin
                work_next = '0;
                if (code == ones)
                begin
                    work_next.alpha = ALPHA_OPAQUE;
                end
                else
                begin
                    work_next.status = ST_NOT_FOUND;
                end
            end
            CMD_RES_COLOR:
            begin
                work_next.red    = col_rd_reg[23:16];
                work_next.green  = col_rd_reg[15:8];
                work_next.blue   = col_rd_reg[7:0];
                work_next.alpha  = (mask_present_reg && !item_reg.mask_bit) ? 8'h00
                                                                            : ALPHA_OPAQUE;
                work_next.status = ST_OK;
            end
            default:
            begin
                work_next = work_reg;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        work_reg <= work_next;
    end

    // Output register.
    logic out_valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.op == CMD_OUT)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.op == CMD_OUT)
        begin
            res <= work_reg;
        end
    end

    assign out_valid = out_valid_reg;

endmodule

### rtl/pixel_map_color_decode_unit.sv
// ----------------------------------------------------------------------------
// pixel_map_color_decode_unit
// Decodes indexed (through a color table) and direct pixel codes to 8-bit RGBA.
// ----------------------------------------------------------------------------
//  Channel   Dir  Carries
//  pix_in    in   pixel code or color table entry write
//  pix_out   out  red, green, blue, alpha, status
//  cfg       in   write enable, register index, write data
//
// One transaction is in work at a time. Table writes, direct pixels, format
// errors and slot misses go from decode straight to finish; slot hits pass
// through the color read first. Number matching scans the color number memory
// one entry per cycle until a number matches or the last loaded slot is passed.
// A stalled output holds the unit in the finish state and delays the next accept.
// The output register holds a result while the next transaction is accepted.
// The color table is not cleared by reset.
`include "assert_macros.svh"

module pixel_map_color_decode_unit
    import pmcd_pkg::*;
#(
    parameter int TABLE_DEPTH = PMCD_TABLE_DEPTH
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    pmcd_req_if.sink              pix_in,
    pmcd_res_if.source            pix_out,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    pmcd_cmd_t cmd;
    pmcd_sts_t sts;
    pmcd_req_t req;
    pmcd_res_t res;
    logic      in_ready;
    logic      out_valid;

    // Pack the request fields.
    assign req.req_type     = pix_in.req_type;
    assign req.pixel_value  = pix_in.pixel_value;
    assign req.mask_bit     = pix_in.mask_bit;
    assign req.entry_slot   = pix_in.entry_slot;
    assign req.entry_number = pix_in.entry_number;
    assign req.entry_red    = pix_in.entry_red;
    assign req.entry_green  = pix_in.entry_green;
    assign req.entry_blue   = pix_in.entry_blue;

    pmcd_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (pix_in.valid),
        .in_ready (in_ready),
        .sts      (sts),
        .cmd      (cmd)
    );

    pmcd_datapath #(
        .TABLE_DEPTH (TABLE_DEPTH)
    ) u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .req       (req),
        .cmd       (cmd),
        .sts       (sts),
        .out_valid (out_valid),
        .out_ready (pix_out.ready),
        .res       (res)
    );

    // Drive the channels.
    assign pix_in.ready   = in_ready;
    assign pix_out.valid  = out_valid;
    assign pix_out.red    = res.red;
    assign pix_out.green  = res.green;
    assign pix_out.blue   = res.blue;
    assign pix_out.alpha  = res.alpha;
    assign pix_out.status = res.status;

    // Checks.
    `PMCD_ASSERT_NEXT(a_one_in_flight, clk, rst_n, pix_in.valid && pix_in.ready, !pix_in.ready)
    `PMCD_ASSERT_IMPL(a_no_overwrite, clk, rst_n, cmd.op == CMD_OUT, !pix_out.valid || pix_out.ready)
    `PMCD_ASSERT_IMPL(a_err_black, clk, rst_n, pix_out.valid && (pix_out.status != ST_OK), (pix_out.red == 8'd0) && (pix_out.green == 8'd0) && (pix_out.blue == 8'd0) && (pix_out.alpha == 8'd0))

endmodule
